### design/ycc2rgb_pkg.sv
// ycc2rgb_pkg: shared constants, register index codes and the gamma table function
// for the ycbcr to linear rgb converter. No dependencies.
`default_nettype none

package ycc2rgb_pkg;

   localparam int COEFF_FRAC_BITS_DEF  = 12;
   localparam int GAMMA_INDEX_BITS_DEF = 10;

   localparam int NUM_CH      = 3;
   localparam int NUM_REGS    = 7;
   localparam int COEFF_W     = 16;
   localparam int SAMPLE_W    = 8;
   localparam int LIN_W       = 16;
   localparam int CSR_ADDR_W  = 3;
   localparam int PIPE_DEPTH  = 6;

   // offset luma, products and their three-term sum
   localparam int Y_W         = 9;
   localparam int PROD_W      = 25;
   localparam int SUM_W       = 26;
   localparam int LUMA_OFFSET = 16;

   // wide enough for 65535^5 * 2^5 * 65535^11
   localparam int BIG_W       = 272;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_LUMA_GAIN     = 3'd0,
      REG_RED_FROM_CB   = 3'd1,
      REG_RED_FROM_CR   = 3'd2,
      REG_GREEN_FROM_CB = 3'd3,
      REG_GREEN_FROM_CR = 3'd4,
      REG_BLUE_FROM_CB  = 3'd5,
      REG_BLUE_FROM_CR  = 3'd6
   } csr_index_type;

   localparam logic signed [COEFF_W-1:0] COEFF_RESET [NUM_REGS] = '{
      16'sd4096, 16'sd0, 16'sd5616, -16'sd1376, -16'sd2859, 16'sd7094, 16'sd0
   };

   localparam csr_index_type CB_REG [NUM_CH] = '{
      REG_RED_FROM_CB, REG_GREEN_FROM_CB, REG_BLUE_FROM_CB
   };
   localparam csr_index_type CR_REG [NUM_CH] = '{
      REG_RED_FROM_CR, REG_GREEN_FROM_CR, REG_BLUE_FROM_CR
   };

   // round(65535 * (idx/m)^(11/5)), ties upward, exact integer search
   function automatic logic [LIN_W-1:0] gamma_entry(input int unsigned idx,
                                                    input int unsigned m);
      logic [BIG_W-1:0] rhs;
      logic [BIG_W-1:0] lhs;
      int unsigned      lo;
      int unsigned      hi;
      int unsigned      mid;
      int unsigned      x;
      x   = (idx > m) ? m : idx;
      rhs = BIG_W'(1);
      for (int i = 0; i < 5; i++) begin
         rhs = rhs * BIG_W'(2) * BIG_W'(65535);
      end
      for (int i = 0; i < 11; i++) begin
         rhs = rhs * BIG_W'(x);
      end
      lo = 0;
      hi = 65535;
      for (int s = 0; s < 17; s++) begin
         if (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            lhs = BIG_W'(1);
            for (int i = 0; i < 5; i++) begin
               lhs = lhs * BIG_W'(2 * mid - 1);
            end
            for (int i = 0; i < 11; i++) begin
               lhs = lhs * BIG_W'(m);
            end
            if (lhs <= rhs) begin
               lo = mid;
            end else begin
               hi = mid - 1;
            end
         end
      end
      return LIN_W'(lo);
   endfunction

endpackage

`default_nettype wire

### design/ycbcr_to_linear_rgb_gamma.sv
// ycbcr_to_linear_rgb_gamma: pipelined ycbcr to linear rgb converter with gamma 2.2
// expansion through per-channel lookup roms. Depends on ycc2rgb_pkg.
//
// Takes one pixel (Y, Cb, Cr, 8 bits each) per request and returns linear 16-bit
// R, G, B where 65535 means 1.0. Offsets 16 and 128 are removed, a programmable
// matrix (shared luma gain, six signed chroma weights, COEFF_FRAC_BITS fraction
// bits) forms each channel, which is clamped to 0..255, quantized to a
// GAMMA_INDEX_BITS table index with rounding and expanded by a gamma 2.2 rom.
// The pipeline is six registers deep, and one pixel is taken every clock while the
// output is not stalled; the rate is set by the multipliers and the registered rom
// read, each done within its own stage. A stall on the result side holds the whole
// pipeline. The user must write coefficients through the csr port only while no pixel
// is in flight; the block does not enforce this. Indexes above six are ignored.
`default_nettype none

module ycbcr_to_linear_rgb_gamma
   import ycc2rgb_pkg::*;
#(
   parameter int COEFF_FRAC_BITS  = COEFF_FRAC_BITS_DEF,
   parameter int GAMMA_INDEX_BITS = GAMMA_INDEX_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // luma [7:0], chroma_blue [15:8], chroma_red [23:16]
   input  logic [NUM_CH*SAMPLE_W-1:0]    req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // red_linear [15:0], green_linear [31:16], blue_linear [47:32]
   output logic [NUM_CH*LIN_W-1:0]       rsp_tdata,
   input  logic                          csr_we,
   input  logic [CSR_ADDR_W-1:0]         csr_addr,
   input  logic [COEFF_W-1:0]            csr_wdata
);

   localparam int          GAMMA_DEPTH = 1 << GAMMA_INDEX_BITS;
   localparam int unsigned GAMMA_MAX   = GAMMA_DEPTH - 1;
   localparam int          ACC_W       = COEFF_FRAC_BITS + 8;
   localparam int          NUM_W       = COEFF_FRAC_BITS + GAMMA_INDEX_BITS + 9;
   localparam int          Q_W         = GAMMA_INDEX_BITS + 8;
   localparam int          RECIP_SHIFT = GAMMA_INDEX_BITS + 16;
   localparam int          RECIP_W     = GAMMA_INDEX_BITS + 9;
   localparam int          PRODQ_W     = Q_W + RECIP_W;

   // ceil(2^RECIP_SHIFT / 255): exact floor division by 255 for q below 2^Q_W
   localparam logic [63:0]        RECIP_WIDE = ((64'd1 << RECIP_SHIFT) + 64'd254) / 64'd255;
   localparam logic [RECIP_W-1:0] RECIP      = RECIP_W'(RECIP_WIDE);
   localparam logic [ACC_W-1:0]   FULL_SCALE = ACC_W'(255) << COEFF_FRAC_BITS;
   localparam logic [NUM_W-1:0]   ROUND_TERM = NUM_W'(FULL_SCALE);
   localparam logic [Q_W-1:0]     Q_LIMIT    = Q_W'(255 * GAMMA_MAX + 127);

   logic signed [COEFF_W-1:0]  coeff_ff [NUM_REGS];

   logic [PIPE_DEPTH-1:0]      vld_ff;
   logic                       advance;

   logic signed [Y_W-1:0]      y_in;
   logic signed [SAMPLE_W-1:0] cb_in;
   logic signed [SAMPLE_W-1:0] cr_in;
   logic signed [Y_W-1:0]      y_ff;
   logic signed [SAMPLE_W-1:0] cb_ff;
   logic signed [SAMPLE_W-1:0] cr_ff;

   logic signed [PROD_W-1:0]   ymul_in;
   logic signed [PROD_W-1:0]   ymul_ff;
   logic signed [PROD_W-1:0]   cbmul_in [NUM_CH];
   logic signed [PROD_W-1:0]   crmul_in [NUM_CH];
   logic signed [PROD_W-1:0]   cbmul_ff [NUM_CH];
   logic signed [PROD_W-1:0]   crmul_ff [NUM_CH];

   logic signed [SUM_W-1:0]    sum_in   [NUM_CH];
   logic [ACC_W-1:0]           acc_in   [NUM_CH];
   logic [ACC_W-1:0]           acc_ff   [NUM_CH];

   logic [NUM_W-1:0]           num_in   [NUM_CH];
   logic [Q_W-1:0]             q_in     [NUM_CH];
   logic [Q_W-1:0]             q_ff     [NUM_CH];

   logic [PRODQ_W-1:0]         recip_in [NUM_CH];
   logic [GAMMA_INDEX_BITS-1:0] idx_in  [NUM_CH];
   logic [GAMMA_INDEX_BITS-1:0] idx_ff  [NUM_CH];

   logic [LIN_W-1:0]           gamma_rom [NUM_CH][GAMMA_DEPTH];
   logic [LIN_W-1:0]           lin_ff   [NUM_CH];

   // coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff <= COEFF_RESET;
      end else if (csr_we && csr_addr <= REG_BLUE_FROM_CR) begin
         coeff_ff[csr_addr] <= csr_wdata;
      end
   end

   // whole pipeline moves together unless the result is held
   assign advance    = !vld_ff[PIPE_DEPTH-1] || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = vld_ff[PIPE_DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_tvalid};
      end
   end

   // stage 0: remove offsets (chroma offset is a flip of the top bit)
   assign y_in  = $signed({1'b0, req_tdata[SAMPLE_W-1:0]}) - Y_W'(LUMA_OFFSET);
   assign cb_in = {~req_tdata[2*SAMPLE_W-1], req_tdata[2*SAMPLE_W-2:SAMPLE_W]};
   assign cr_in = {~req_tdata[3*SAMPLE_W-1], req_tdata[3*SAMPLE_W-2:2*SAMPLE_W]};

   // stage 1: matrix products, luma product shared by all channels
   assign ymul_in = coeff_ff[REG_LUMA_GAIN] * y_ff;

   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         cbmul_in[ch] = coeff_ff[CB_REG[ch]] * cb_ff;
         crmul_in[ch] = coeff_ff[CR_REG[ch]] * cr_ff;
      end
   end

   // stage 2: sum and clamp to 0..255 in coefficient units
   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         sum_in[ch] = SUM_W'(ymul_ff) + SUM_W'(cbmul_ff[ch]) + SUM_W'(crmul_ff[ch]);
         if (sum_in[ch][SUM_W-1]) begin
            acc_in[ch] = '0;
         end else if (sum_in[ch][SUM_W-2:0] > (SUM_W-1)'(FULL_SCALE)) begin
            acc_in[ch] = FULL_SCALE;
         end else begin
            acc_in[ch] = ACC_W'(sum_in[ch]);
         end
      end
   end

   // stage 3: q = (2*acc*M + D) >> (frac+1), M = 2^bits - 1 by shift and subtract
   // stage 4: idx = floor(q / 255) by reciprocal multiply
   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         num_in[ch]   = (NUM_W'(acc_ff[ch]) << (GAMMA_INDEX_BITS + 1))
                        - (NUM_W'(acc_ff[ch]) << 1) + ROUND_TERM;
         q_in[ch]     = num_in[ch][NUM_W-1:COEFF_FRAC_BITS+1];
         recip_in[ch] = PRODQ_W'(q_ff[ch]) * PRODQ_W'(RECIP);
         idx_in[ch]   = recip_in[ch][RECIP_SHIFT +: GAMMA_INDEX_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         y_ff    <= y_in;
         cb_ff   <= cb_in;
         cr_ff   <= cr_in;
         ymul_ff <= ymul_in;
         for (int ch = 0; ch < NUM_CH; ch++) begin
            cbmul_ff[ch] <= cbmul_in[ch];
            crmul_ff[ch] <= crmul_in[ch];
            acc_ff[ch]   <= acc_in[ch];
            q_ff[ch]     <= q_in[ch];
            idx_ff[ch]   <= idx_in[ch];
         end
      end
   end

   // gamma roms, one copy per channel, contents fixed at elaboration
   for (genvar e = 0; e < GAMMA_DEPTH; e++) begin : g_gamma
      localparam logic [LIN_W-1:0] ENTRY = gamma_entry(e, GAMMA_MAX);
      for (genvar c = 0; c < NUM_CH; c++) begin : g_copy
         assign gamma_rom[c][e] = ENTRY;
      end
   end

   // stage 5: registered rom read
   for (genvar c = 0; c < NUM_CH; c++) begin : g_lin
      always_ff @(posedge clock) begin
         if (advance) begin
            lin_ff[c] <= gamma_rom[c][idx_ff[c]];
         end
      end
      assign rsp_tdata[c*LIN_W +: LIN_W] = lin_ff[c];
   end

   // clamp keeps the accumulator within full scale
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[2] |-> (acc_ff[0] <= FULL_SCALE && acc_ff[1] <= FULL_SCALE
                     && acc_ff[2] <= FULL_SCALE))
      else $error("accumulator above full scale after clamp");

   // scaled value never maps beyond the last table entry
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] |-> (q_ff[0] <= Q_LIMIT && q_ff[1] <= Q_LIMIT && q_ff[2] <= Q_LIMIT))
      else $error("scaled index source out of range");

   // black and full white ends of the gamma table
   assert property (@(posedge clock) disable iff (reset)
      (vld_ff[4] && advance && idx_ff[0] == '0) |=> lin_ff[0] == '0)
      else $error("index zero did not give zero output");

   assert property (@(posedge clock) disable iff (reset)
      (vld_ff[4] && advance && idx_ff[0] == '1) |=> lin_ff[0] == '1)
      else $error("top index did not give full scale output");

   // a held result freezes the valid flags of every stage
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(vld_ff))
      else $error("pipeline moved while result was held");

endmodule

`default_nettype wire

### test/ycbcr_to_linear_rgb_gamma_tb.sv
// ycbcr_to_linear_rgb_gamma_tb: self-checking bench for the ycbcr to linear rgb converter.
// Drives random and directed pixels under several coefficient sets, predicts each rgb
// result in place and compares it in order. Depends on ycc2rgb_pkg and the converter.

module ycbcr_to_linear_rgb_gamma_tb;
   import ycc2rgb_pkg::*;

   localparam int          GAMMA_MAX   = (1 << GAMMA_INDEX_BITS_DEF) - 1;
   localparam longint      FULL_SCALE  = longint'(255) << COEFF_FRAC_BITS_DEF;
   localparam int          CYCLE_LIMIT = 200000;
   localparam logic [CSR_ADDR_W-1:0] SPARE_REG_INDEX = 3'd7;

   typedef struct packed {
      logic [SAMPLE_W-1:0] chroma_red;
      logic [SAMPLE_W-1:0] chroma_blue;
      logic [SAMPLE_W-1:0] luma;
   } pixel_type;

   typedef struct packed {
      logic [LIN_W-1:0] blue_linear;
      logic [LIN_W-1:0] green_linear;
      logic [LIN_W-1:0] red_linear;
   } rgb_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   pixel_type                  req_tdata = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [NUM_CH*LIN_W-1:0]    rsp_tdata;
   logic                       csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]      csr_addr = '0;
   logic [COEFF_W-1:0]         csr_wdata = '0;

   logic signed [COEFF_W-1:0]  coef [NUM_REGS];
   logic [LIN_W-1:0]           gamma_lut [0:GAMMA_MAX];
   pixel_type                  pixel_q [$];
   rgb_type                    rgb_expect_q [$];
   logic                       idle_enable = 1'b1;
   int                         send_gap = 0;
   int                         recv_hold = 0;
   int                         mismatch_count = 0;
   int                         pixels_sent = 0;
   int                         results_checked = 0;
   int                         coef_sets = 0;
   int                         cycle_count = 0;

   ycbcr_to_linear_rgb_gamma u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic logic [255:0] pow_wide(longint unsigned base, int n);
      logic [255:0] p;
      p = 256'd1;
      for (int i = 0; i < n; i++) begin
         p = p * 256'(base);
      end
      return p;
   endfunction

   // start from the real-valued curve, then settle on the exact half-up rounding
   task automatic build_gamma_lut;
      logic [255:0] m_pow;
      logic [255:0] bound;
      real          ratio;
      int           lin;
      m_pow = pow_wide(GAMMA_MAX, 11);
      for (int idx = 0; idx <= GAMMA_MAX; idx++) begin
         bound = pow_wide(2, 5) * pow_wide(65535, 5) * pow_wide(idx, 11);
         ratio = real'(idx) / real'(GAMMA_MAX);
         lin   = int'(65535.0 * (ratio ** 2.2));
         if (lin > 65535) lin = 65535;
         if (lin < 0) lin = 0;
         while (lin < 65535 && pow_wide(2 * lin + 1, 5) * m_pow <= bound) lin++;
         while (lin > 0 && pow_wide(2 * lin - 1, 5) * m_pow > bound) lin--;
         gamma_lut[idx] = LIN_W'(lin);
      end
   endtask

   function automatic logic [LIN_W-1:0] channel_linear(int y, int cb, int cr,
                                                       logic signed [COEFF_W-1:0] k_cb,
                                                       logic signed [COEFF_W-1:0] k_cr);
      longint acc;
      longint idx;
      acc = longint'(coef[REG_LUMA_GAIN]) * y + longint'(k_cb) * cb + longint'(k_cr) * cr;
      if (acc < 0) acc = 0;
      if (acc > FULL_SCALE) acc = FULL_SCALE;
      idx = (acc * 2 * GAMMA_MAX + FULL_SCALE) / (2 * FULL_SCALE);
      return gamma_lut[idx];
   endfunction

   function automatic rgb_type predict_rgb(pixel_type pix);
      rgb_type rgb;
      int      y;
      int      cb;
      int      cr;
      y  = int'(pix.luma) - LUMA_OFFSET;
      cb = int'(pix.chroma_blue) - 128;
      cr = int'(pix.chroma_red) - 128;
      rgb.red_linear   = channel_linear(y, cb, cr, coef[REG_RED_FROM_CB], coef[REG_RED_FROM_CR]);
      rgb.green_linear = channel_linear(y, cb, cr, coef[REG_GREEN_FROM_CB],
                                        coef[REG_GREEN_FROM_CR]);
      rgb.blue_linear  = channel_linear(y, cb, cr, coef[REG_BLUE_FROM_CB],
                                        coef[REG_BLUE_FROM_CR]);
      return rgb;
   endfunction

   task automatic report_mismatch(string what, logic [LIN_W-1:0] want, logic [LIN_W-1:0] got);
      $display("%0t: %s: expected 0x%04h, got 0x%04h", $time, what, want, got);
      mismatch_count++;
   endtask

   task automatic check_rgb(rgb_type got);
      rgb_type want;
      if (rgb_expect_q.size() == 0) begin
         report_mismatch("result with no pending request", '0, got.red_linear);
      end else begin
         want = rgb_expect_q.pop_front();
         if (got.red_linear !== want.red_linear)
            report_mismatch("red_linear", want.red_linear, got.red_linear);
         if (got.green_linear !== want.green_linear)
            report_mismatch("green_linear", want.green_linear, got.green_linear);
         if (got.blue_linear !== want.blue_linear)
            report_mismatch("blue_linear", want.blue_linear, got.blue_linear);
      end
      results_checked++;
   endtask

   // request driver: predicts on acceptance, inserts random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            rgb_expect_q.push_back(predict_rgb(req_tdata));
            pixels_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap   <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 5) == 0) begin
               send_gap   <= $urandom_range(0, 13);
               req_tvalid <= 1'b0;
            end else if (pixel_q.size() != 0) begin
               req_tdata  <= pixel_q.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor with random backpressure bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_hold  <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_rgb(rgb_type'(rsp_tdata));
         if (recv_hold > 0) begin
            recv_hold  <= recv_hold - 1;
            rsp_tready <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            recv_hold  <= $urandom_range(0, 13);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic write_csr(logic [CSR_ADDR_W-1:0] addr, logic [COEFF_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      if (addr < NUM_REGS) coef[addr] = value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic write_matrix(logic [COEFF_W-1:0] gain, logic [COEFF_W-1:0] r_cb,
                               logic [COEFF_W-1:0] r_cr, logic [COEFF_W-1:0] g_cb,
                               logic [COEFF_W-1:0] g_cr, logic [COEFF_W-1:0] b_cb,
                               logic [COEFF_W-1:0] b_cr);
      write_csr(REG_LUMA_GAIN, gain);
      write_csr(REG_RED_FROM_CB, r_cb);
      write_csr(REG_RED_FROM_CR, r_cr);
      write_csr(REG_GREEN_FROM_CB, g_cb);
      write_csr(REG_GREEN_FROM_CR, g_cr);
      write_csr(REG_BLUE_FROM_CB, b_cb);
      write_csr(REG_BLUE_FROM_CR, b_cr);
      coef_sets++;
   endtask

   function automatic logic [COEFF_W-1:0] random_coef(int span);
      return COEFF_W'($urandom_range(0, 2 * span) - span);
   endfunction

   task automatic queue_pixel(int y, int cb, int cr);
      pixel_type pix;
      pix.luma        = SAMPLE_W'(y);
      pix.chroma_blue = SAMPLE_W'(cb);
      pix.chroma_red  = SAMPLE_W'(cr);
      pixel_q.push_back(pix);
   endtask

   // mostly studio-range video, the rest anywhere in 0..255
   task automatic queue_random_pixels(int count);
      @(negedge clock);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 3) != 0)
            queue_pixel($urandom_range(16, 235), $urandom_range(16, 240),
                        $urandom_range(16, 240));
         else
            queue_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255));
      end
   endtask

   task automatic wait_drained;
      @(negedge clock);
      while (pixel_q.size() != 0 || req_tvalid || rgb_expect_q.size() != 0)
         @(negedge clock);
      repeat (PIPE_DEPTH + 2) @(negedge clock);
   endtask

   initial begin
      for (int i = 0; i < NUM_REGS; i++) coef[i] = COEFF_RESET[i];
      build_gamma_lut();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset coefficients: black, white, field extremes, clamps, bit patterns, primaries
      @(negedge clock);
      queue_pixel(16, 128, 128);
      queue_pixel(235, 128, 128);
      queue_pixel(0, 0, 0);
      queue_pixel(255, 255, 255);
      queue_pixel(0, 128, 128);    // luma below black clamps to zero
      queue_pixel(255, 128, 128);  // luma above white, still short of full scale
      queue_pixel(255, 0, 255);
      queue_pixel(0, 255, 0);
      queue_pixel(128, 255, 128);
      queue_pixel(128, 0, 128);
      queue_pixel(128, 128, 255);
      queue_pixel(128, 128, 0);
      queue_pixel(170, 85, 170);
      queue_pixel(85, 170, 85);
      queue_pixel(81, 90, 240);
      queue_pixel(145, 54, 34);
      queue_pixel(41, 240, 110);
      queue_pixel(126, 128, 128);
      wait_drained();

      // a write past the last register must leave the matrix alone
      write_csr(SPARE_REG_INDEX, 16'hFFFF);
      queue_random_pixels(55);
      wait_drained();

      write_matrix(16'sd4096, 16'sd0, 16'sd6451, -16'sd767, -16'sd1918, 16'sd7601, 16'sd0);
      queue_random_pixels(55);
      wait_drained();

      write_matrix(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      queue_random_pixels(55);
      wait_drained();

      write_matrix(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      queue_random_pixels(55);
      wait_drained();

      write_matrix('0, '0, '0, '0, '0, '0, '0);
      queue_random_pixels(25);
      wait_drained();

      for (int set = 0; set < 3; set++) begin
         write_matrix(random_coef(32768), random_coef(32768), random_coef(32768),
                      random_coef(32768), random_coef(32768), random_coef(32768),
                      random_coef(32768));
         queue_random_pixels(45);
         wait_drained();
      end

      // moderate weights keep most channels inside the unclamped range
      write_matrix(COEFF_W'($urandom_range(3000, 5500)), random_coef(8192), random_coef(8192),
                   random_coef(8192), random_coef(8192), random_coef(8192), random_coef(8192));
      queue_random_pixels(55);
      wait_drained();

      // back to the power-on matrix at full rate on both sides
      idle_enable = 1'b0;
      write_matrix(COEFF_RESET[0], COEFF_RESET[1], COEFF_RESET[2], COEFF_RESET[3],
                   COEFF_RESET[4], COEFF_RESET[5], COEFF_RESET[6]);
      queue_random_pixels(60);
      wait_drained();

      $display("sent %0d pixels under %0d coefficient sets plus the power-on matrix",
               pixels_sent, coef_sets);
      $display("compared %0d rgb results, %0d field mismatches", results_checked,
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
